// ===== hw/rtl/jtedt_pkg.sv =====
// shared types and constants of the jump target encoder
package jtedt_pkg;

   localparam logic [31:0] EXTERNAL_TAG = 32'h8000_0000;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_BASE      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_WORD     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GUEST_TABLE_BASE = 2'd2;

   localparam logic [63:0] WINDOW_BASE_RESET      = 64'd0;
   localparam logic [31:0] DEFAULT_WORD_RESET     = 32'd0;
   localparam logic [31:0] GUEST_TABLE_BASE_RESET = 32'h8000_0000;

   localparam logic [1:0] PATH_WINDOW   = 2'd0;
   localparam logic [1:0] PATH_EXT_HIT  = 2'd1;
   localparam logic [1:0] PATH_EXT_NEW  = 2'd2;
   localparam logic [1:0] PATH_OVERFLOW = 2'd3;

   typedef struct packed {
      logic        slot_valid;
      logic [28:0] slot_index;
      logic        in_window;
      logic [31:0] window_offset;
   } classify_type;

   typedef struct packed {
      logic        done;
      logic [31:0] word;
      logic [1:0]  path;
   } scan_result_type;

endpackage

// ===== hw/rtl/jtedt_req_if.sv =====
// request channel: guest address and host target
interface jtedt_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] guest_addr;
   logic [63:0] host_target;

   modport source (output valid, output guest_addr, output host_target, input ready);
   modport sink   (input valid, input guest_addr, input host_target, output ready);
endinterface

// ===== hw/rtl/jtedt_rsp_if.sv =====
// response channel: slot and encoded word
interface jtedt_rsp_if;
   logic        valid;
   logic        ready;
   logic        slot_valid;
   logic [28:0] slot_index;
   logic [31:0] encoded_word;
   logic [1:0]  path_code;

   modport source (output valid, output slot_valid, output slot_index, output encoded_word,
                   output path_code, input ready);
   modport sink   (input valid, input slot_valid, input slot_index, input encoded_word,
                   input path_code, output ready);
endinterface

// ===== hw/rtl/jtedt_csr_if.sv =====
// configuration write channel
interface jtedt_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/jump_target_encode_dedup_table_unit.sv =====
// top level of the jump target encoder with external target table
//
// channels: req_ch takes a guest address and a 64-bit host target, rsp_ch
// returns slot_valid, slot_index, encoded_word and path_code, one response
// per request, in order. csr_ch writes the code window base (index 0),
// default_word (index 1) and guest_table_base (index 2); other indexes are
// ignored. csr_ch is always ready; the user must write it only while no
// request is in flight, as the block itself does not enforce it.
//
// a request outside the slot table or inside the code window goes from the
// request registers straight to the response register. otherwise the external
// table memory is read one entry per cycle, stopping on a hit, or after all
// stored targets on a new target or a full table.
// one request is in work at a time; req_ch.ready is high when idle.
//
// reset clears the target count, the configuration registers and the
// response register; table contents need no clearing. a stalled rsp_ch
// holds the response, and the next request can be accepted and worked on
// meanwhile, its result waiting until the response register frees up.
module jump_target_encode_dedup_table_unit #(
   parameter int          EXT_CAPACITY      = 64,
   parameter logic [30:0] CODE_WINDOW_BYTES = 31'd268435455,
   parameter logic [32:0] SLOT_TABLE_BYTES  = 33'd2147483648
) (
   input  logic        clock,
   input  logic        reset,
   jtedt_req_if.sink   req_ch,
   jtedt_rsp_if.source rsp_ch,
   jtedt_csr_if.sink   csr_ch
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [63:0] window_base_ff, window_base_in;
   logic [31:0] default_word_ff, default_word_in;
   logic [31:0] slot_base_ff, slot_base_in;

   logic        slot_valid_ff, slot_valid_in;
   logic [28:0] slot_index_ff, slot_index_in;
   logic [31:0] word_ff, word_in;
   logic [1:0]  path_ff, path_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_slot_valid_ff, rsp_slot_valid_in;
   logic [28:0] rsp_slot_index_ff, rsp_slot_index_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic [1:0]  rsp_path_ff, rsp_path_in;

   jtedt_pkg::classify_type    cls;
   jtedt_pkg::scan_result_type scan_res;
   logic                       req_fire;
   logic                       scan_start;
   logic                       rsp_free;

   jtedt_classify #(
      .CODE_WINDOW_BYTES (CODE_WINDOW_BYTES),
      .SLOT_TABLE_BYTES  (SLOT_TABLE_BYTES)
   ) u_classify (
      .guest_addr       (req_ch.guest_addr),
      .host_target      (req_ch.host_target),
      .window_base      (window_base_ff),
      .guest_table_base (slot_base_ff),
      .cls              (cls)
   );

   jtedt_scan #(
      .EXT_CAPACITY (EXT_CAPACITY)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .start        (scan_start),
      .target       (req_ch.host_target),
      .default_word (default_word_ff),
      .result       (scan_res)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign scan_start   = req_fire && cls.slot_valid && !cls.in_window;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      window_base_in  = window_base_ff;
      default_word_in = default_word_ff;
      slot_base_in    = slot_base_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            jtedt_pkg::CSR_WINDOW_BASE:      window_base_in  = csr_ch.data;
            jtedt_pkg::CSR_DEFAULT_WORD:     default_word_in = csr_ch.data[31:0];
            jtedt_pkg::CSR_GUEST_TABLE_BASE: slot_base_in    = csr_ch.data[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in          = state_ff;
      slot_valid_in     = slot_valid_ff;
      slot_index_in     = slot_index_ff;
      word_in           = word_ff;
      path_in           = path_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ch.ready;
      rsp_slot_valid_in = rsp_slot_valid_ff;
      rsp_slot_index_in = rsp_slot_index_ff;
      rsp_word_in       = rsp_word_ff;
      rsp_path_in       = rsp_path_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               slot_valid_in = cls.slot_valid;
               slot_index_in = cls.slot_index;
               path_in       = jtedt_pkg::PATH_WINDOW;
               word_in       = (cls.slot_valid && cls.in_window) ? cls.window_offset : 32'd0;
               state_in      = scan_start ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (scan_res.done) begin
               word_in  = scan_res.word;
               path_in  = scan_res.path;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in      = 1'b1;
               rsp_slot_valid_in = slot_valid_ff;
               rsp_slot_index_in = slot_index_ff;
               rsp_word_in       = word_ff;
               rsp_path_in       = path_ff;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         window_base_ff  <= jtedt_pkg::WINDOW_BASE_RESET;
         default_word_ff <= jtedt_pkg::DEFAULT_WORD_RESET;
         slot_base_ff    <= jtedt_pkg::GUEST_TABLE_BASE_RESET;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         window_base_ff  <= window_base_in;
         default_word_ff <= default_word_in;
         slot_base_ff    <= slot_base_in;
      end
      slot_valid_ff     <= slot_valid_in;
      slot_index_ff     <= slot_index_in;
      word_ff           <= word_in;
      path_ff           <= path_in;
      rsp_slot_valid_ff <= rsp_slot_valid_in;
      rsp_slot_index_ff <= rsp_slot_index_in;
      rsp_word_ff       <= rsp_word_in;
      rsp_path_ff       <= rsp_path_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.slot_valid   = rsp_slot_valid_ff;
   assign rsp_ch.slot_index   = rsp_slot_index_ff;
   assign rsp_ch.encoded_word = rsp_word_ff;
   assign rsp_ch.path_code    = rsp_path_ff;

endmodule

// ===== hw/rtl/jtedt_ram.sv =====
// generic single-write, single-read ram with registered read data
module jtedt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/jtedt_classify.sv =====
// slot range check and code window test of one request
module jtedt_classify #(
   parameter logic [30:0] CODE_WINDOW_BYTES = 31'd268435455,
   parameter logic [32:0] SLOT_TABLE_BYTES  = 33'd2147483648
) (
   input  logic [31:0]            guest_addr,
   input  logic [63:0]            host_target,
   input  logic [63:0]            window_base,
   input  logic [31:0]            guest_table_base,
   output jtedt_pkg::classify_type cls
);

   logic [31:0] delta;
   logic [33:0] slot_end;
   logic        slot_ok;
   logic [64:0] diff;

   always_comb begin
      delta    = guest_addr - guest_table_base;
      slot_end = {2'b00, delta[31:2], 2'b00} + 34'd4;
      slot_ok  = (guest_addr >= guest_table_base) && (slot_end <= {1'b0, SLOT_TABLE_BYTES});
      diff     = {1'b0, host_target} - {1'b0, window_base};

      cls.slot_valid    = slot_ok;
      cls.slot_index    = slot_ok ? delta[30:2] : 29'd0;
      cls.in_window     = !diff[64] && (diff[63:0] < {33'd0, CODE_WINDOW_BYTES});
      cls.window_offset = diff[31:0];
   end

endmodule

// ===== hw/rtl/jtedt_scan.sv =====
// search and append in the external target table
module jtedt_scan #(
   parameter int EXT_CAPACITY = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [63:0]                target,
   input  logic [31:0]                default_word,
   output jtedt_pkg::scan_result_type result
);

   localparam int CNT_W = $clog2(EXT_CAPACITY + 1);
   localparam int IDX_W = EXT_CAPACITY > 1 ? $clog2(EXT_CAPACITY) : 1;
   localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(EXT_CAPACITY);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic             state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [63:0]      target_ff, target_in;
   jtedt_pkg::scan_result_type result_ff, result_in;

   logic             wr_en;
   logic [63:0]      rd_data;
   logic             hit;

   jtedt_ram #(
      .WIDTH (64),
      .DEPTH (EXT_CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (target_ff),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      scan_in    = scan_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      target_in  = target_ff;
      result_in  = result_ff;
      result_in.done = 1'b0;
      wr_en      = 1'b0;
      hit        = cmp_vld_ff && (rd_data == target_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in  = ST_RUN;
               scan_in   = '0;
               target_in = target;
            end
         end
         ST_RUN: begin
            if (hit) begin
               state_in         = ST_IDLE;
               result_in.done   = 1'b1;
               result_in.path   = jtedt_pkg::PATH_EXT_HIT;
               result_in.word   = jtedt_pkg::EXTERNAL_TAG | {{(32-IDX_W){1'b0}}, cmp_idx_ff};
            end else if (scan_ff != count_ff) begin
               scan_in    = scan_ff + 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[IDX_W-1:0];
            end else if (count_ff >= CAPACITY) begin
               state_in       = ST_IDLE;
               result_in.done = 1'b1;
               result_in.path = jtedt_pkg::PATH_OVERFLOW;
               result_in.word = default_word;
            end else begin
               state_in       = ST_IDLE;
               wr_en          = 1'b1;
               count_in       = count_ff + 1'b1;
               result_in.done = 1'b1;
               result_in.path = jtedt_pkg::PATH_EXT_NEW;
               result_in.word = jtedt_pkg::EXTERNAL_TAG | 32'(count_ff);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         cmp_vld_ff     <= 1'b0;
         result_ff.done <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         cmp_vld_ff     <= cmp_vld_in;
         result_ff.done <= result_in.done;
      end
      scan_ff        <= scan_in;
      cmp_idx_ff     <= cmp_idx_in;
      target_ff      <= target_in;
      result_ff.word <= result_in.word;
      result_ff.path <= result_in.path;
   end

   assign result = result_ff;

endmodule

// ===== dv/tb_jump_target_encode_dedup_table_unit.sv =====
// testbench of the jump target encoder: directed table, then predictor-checked random requests
module tb_jump_target_encode_dedup_table_unit;

   localparam int          TABLE_DEPTH  = 64;
   localparam logic [63:0] WINDOW_BYTES = 64'd268435455;
   localparam logic [63:0] SLOT_SPAN    = 64'h8000_0000;
   localparam logic [1:0]  CSR_SPARE    = 2'd3;
   localparam int          POOL_SIZE    = 80;
   localparam int          PHASES       = 6;
   localparam int          PHASE_ITEMS  = 182;
   localparam int          CYCLE_LIMIT  = 1_000_000;

   typedef struct packed {
      logic        slot_valid;
      logic [28:0] slot_index;
      logic [31:0] encoded_word;
      logic [1:0]  path_code;
   } slot_word_type;

   typedef struct packed {
      logic [31:0]   guest;
      logic [63:0]   target;
      bit            pinned;
      slot_word_type want;
   } stim_row_type;

   typedef struct packed {
      logic [63:0] window_base;
      logic [31:0] default_word;
      logic [31:0] slot_base;
   } encoder_setting_type;

   logic clock = 1'b0;
   logic reset;

   jtedt_req_if req_ch();
   jtedt_rsp_if rsp_ch();
   jtedt_csr_if csr_ch();

   jump_target_encode_dedup_table_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #4 clock = ~clock;

   // predictor copy of configuration and target table
   logic [63:0] cfg_window_base;
   logic [31:0] cfg_default_word;
   logic [31:0] cfg_slot_base;
   logic [63:0] stored_targets[TABLE_DEPTH];
   int          stored_count;

   logic [63:0]   far_targets[POOL_SIZE];
   slot_word_type pending_slot_words[$];
   int            requests_sent;
   int            responses_seen;
   int            failures;
   int            cycle_count;
   bit            sender_calm;
   bit            rsp_calm;

   stim_row_type directed_rows[15] = '{
      '{32'h0000_0000, 64'h0, 1'b1, '{1'b0, 29'd0, 32'd0, jtedt_pkg::PATH_WINDOW}},
      '{32'h7fff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1,
        '{1'b0, 29'd0, 32'd0, jtedt_pkg::PATH_WINDOW}},
      '{32'h8000_0000, 64'h0, 1'b1, '{1'b1, 29'd0, 32'd0, jtedt_pkg::PATH_WINDOW}},
      '{32'h8000_0003, 64'h0fff_fffe, 1'b1,
        '{1'b1, 29'd0, 32'h0fff_fffe, jtedt_pkg::PATH_WINDOW}},
      '{32'hffff_ffff, 64'h0fff_ffff, 1'b1,
        '{1'b1, 29'h1fff_ffff, jtedt_pkg::EXTERNAL_TAG | 32'd0, jtedt_pkg::PATH_EXT_NEW}},
      '{32'hffff_fffc, 64'h0fff_ffff, 1'b1,
        '{1'b1, 29'h1fff_ffff, jtedt_pkg::EXTERNAL_TAG | 32'd0, jtedt_pkg::PATH_EXT_HIT}},
      '{32'h8000_0004, 64'hffff_ffff_ffff_ffff, 1'b1,
        '{1'b1, 29'd1, jtedt_pkg::EXTERNAL_TAG | 32'd1, jtedt_pkg::PATH_EXT_NEW}},
      '{32'h8000_0008, 64'hffff_ffff_ffff_ffff, 1'b1,
        '{1'b1, 29'd2, jtedt_pkg::EXTERNAL_TAG | 32'd1, jtedt_pkg::PATH_EXT_HIT}},
      '{32'hc000_0000, 64'h8000_0000_0000_0000, 1'b1,
        '{1'b1, 29'h1000_0000, jtedt_pkg::EXTERNAL_TAG | 32'd2, jtedt_pkg::PATH_EXT_NEW}},
      '{32'h8000_0010, 64'h0fff_ffff, 1'b1,
        '{1'b1, 29'd4, jtedt_pkg::EXTERNAL_TAG | 32'd0, jtedt_pkg::PATH_EXT_HIT}},
      '{32'h9234_5678, 64'h0123_4567_89ab_cdef, 1'b0, '0},
      '{32'ha5a5_a5a5, 64'h5a5a_5a5a_5a5a_5a5a, 1'b0, '0},
      '{32'h5a5a_5a5a, 64'h0123_4567_89ab_cdef, 1'b0, '0},
      '{32'h8000_0001, 64'h0000_0000_0000_0001, 1'b0, '0},
      '{32'hbfff_fffe, 64'h0123_4567_89ab_cdef, 1'b0, '0}
   };

   function automatic slot_word_type encode_jump_target(input logic [31:0] guest,
                                                        input logic [63:0] target);
      slot_word_type r;
      logic [31:0]   delta;
      logic [63:0]   diff;
      int            hit;
      r = '0;
      if (guest < cfg_slot_base) return r;
      delta = guest - cfg_slot_base;
      if ((({32'd0, delta} & ~64'd3) + 64'd4) > SLOT_SPAN) return r;
      r.slot_valid = 1'b1;
      r.slot_index = delta[30:2];
      diff = target - cfg_window_base;
      if (target >= cfg_window_base && diff < WINDOW_BYTES) begin
         r.encoded_word = diff[31:0];
         r.path_code    = jtedt_pkg::PATH_WINDOW;
         return r;
      end
      hit = -1;
      for (int k = 0; k < stored_count; k++) begin
         if (hit < 0 && stored_targets[k] == target) hit = k;
      end
      if (hit >= 0) begin
         r.encoded_word = jtedt_pkg::EXTERNAL_TAG | 32'(hit);
         r.path_code    = jtedt_pkg::PATH_EXT_HIT;
      end else if (stored_count >= TABLE_DEPTH) begin
         r.encoded_word = cfg_default_word;
         r.path_code    = jtedt_pkg::PATH_OVERFLOW;
      end else begin
         stored_targets[stored_count] = target;
         r.encoded_word = jtedt_pkg::EXTERNAL_TAG | 32'(stored_count);
         r.path_code    = jtedt_pkg::PATH_EXT_NEW;
         stored_count++;
      end
      return r;
   endfunction

   function automatic int pick_gap(input bit calm);
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   function automatic logic [31:0] pick_guest();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return cfg_slot_base + $urandom_range(0, 32'h7fff_ffff);
         6, 7: return $urandom();
         8: return cfg_slot_base - 32'd1 + $urandom_range(0, 4);
         default: return cfg_slot_base + 32'h7fff_fffc + $urandom_range(0, 7);
      endcase
   endfunction

   function automatic logic [63:0] pick_target();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return far_targets[$urandom_range(0, POOL_SIZE - 1)];
         4, 5, 6: return cfg_window_base + 64'($urandom_range(0, 268435454));
         7: begin
            case ($urandom_range(0, 3))
               0: return cfg_window_base - 64'd1;
               1: return cfg_window_base;
               2: return cfg_window_base + WINDOW_BYTES - 64'd1;
               default: return cfg_window_base + WINDOW_BYTES;
            endcase
         end
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   task automatic send_request(input logic [31:0] guest, input logic [63:0] target,
                               input bit pinned, input slot_word_type want, input int gap);
      slot_word_type predicted;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.guest_addr  <= guest;
      req_ch.host_target <= target;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = encode_jump_target(guest, target);
      pending_slot_words.push_back(pinned ? want : predicted);
      requests_sent++;
   endtask

   task automatic drain_requests();
      if (responses_seen != requests_sent) begin
         req_ch.valid <= 1'b0;
         while (responses_seen != requests_sent) @(posedge clock);
      end
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         jtedt_pkg::CSR_WINDOW_BASE:      cfg_window_base = value;
         jtedt_pkg::CSR_DEFAULT_WORD:     cfg_default_word = value[31:0];
         jtedt_pkg::CSR_GUEST_TABLE_BASE: cfg_slot_base = value[31:0];
         default: ;
      endcase
   endtask

   // response ready with random stalls
   initial begin
      int stall;
      stall = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall = pick_gap(rsp_calm);
         end
      end
   end

   always @(posedge clock) begin : check_responses
      slot_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         responses_seen++;
         if (pending_slot_words.size() == 0) begin
            $display("%0t: response with no request outstanding", $time);
            failures++;
         end else begin
            want = pending_slot_words.pop_front();
            if (rsp_ch.slot_valid !== want.slot_valid) begin
               $display("%0t: slot_valid expected %0d actual %0d", $time,
                        want.slot_valid, rsp_ch.slot_valid);
               failures++;
            end
            if (rsp_ch.slot_index !== want.slot_index) begin
               $display("%0t: slot_index expected %h actual %h", $time,
                        want.slot_index, rsp_ch.slot_index);
               failures++;
            end
            if (rsp_ch.encoded_word !== want.encoded_word) begin
               $display("%0t: encoded_word expected %h actual %h", $time,
                        want.encoded_word, rsp_ch.encoded_word);
               failures++;
            end
            if (rsp_ch.path_code !== want.path_code) begin
               $display("%0t: path_code expected %0d actual %0d", $time,
                        want.path_code, rsp_ch.path_code);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      encoder_setting_type plan[PHASES];
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.guest_addr  <= '0;
      req_ch.host_target <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= jtedt_pkg::CSR_WINDOW_BASE;
      csr_ch.data        <= '0;
      cfg_window_base  = jtedt_pkg::WINDOW_BASE_RESET;
      cfg_default_word = jtedt_pkg::DEFAULT_WORD_RESET;
      cfg_slot_base    = jtedt_pkg::GUEST_TABLE_BASE_RESET;
      stored_count     = 0;
      requests_sent    = 0;
      responses_seen   = 0;
      failures         = 0;
      cycle_count      = 0;
      sender_calm      = 1'b0;
      rsp_calm         = 1'b0;
      foreach (far_targets[k]) far_targets[k] = {$urandom(), $urandom()};

      plan[0].window_base = {$urandom(), $urandom()};
      plan[0].default_word = $urandom();
      plan[0].slot_base = jtedt_pkg::GUEST_TABLE_BASE_RESET;
      plan[1].window_base = 64'hffff_ffff_ffff_ffff;
      plan[1].default_word = 32'hffff_ffff;
      plan[1].slot_base = 32'h0000_0000;
      plan[2].window_base = 64'hffff_ffff_f800_0000;
      plan[2].default_word = 32'h0000_0000;
      plan[2].slot_base = 32'hffff_ffff;
      plan[3].window_base = 64'h0;
      plan[3].default_word = $urandom();
      plan[3].slot_base = $urandom();
      plan[4].window_base = {32'h0, $urandom()};
      plan[4].default_word = 32'hffff_ffff;
      plan[4].slot_base = 32'h7fff_fffc;
      plan[5].window_base = {$urandom(), $urandom()};
      plan[5].default_word = $urandom();
      plan[5].slot_base = $urandom();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].guest, directed_rows[i].target,
                      directed_rows[i].pinned, directed_rows[i].want, pick_gap(sender_calm));
      end

      for (int p = 0; p < PHASES; p++) begin
         drain_requests();
         write_register(jtedt_pkg::CSR_WINDOW_BASE, plan[p].window_base);
         write_register(jtedt_pkg::CSR_DEFAULT_WORD, {32'h0, plan[p].default_word});
         write_register(jtedt_pkg::CSR_GUEST_TABLE_BASE, {32'h0, plan[p].slot_base});
         if (p == 3) write_register(CSR_SPARE, {$urandom(), $urandom()});
         csr_ch.valid <= 1'b0;
         sender_calm = (p == 2);
         rsp_calm    = (p == 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 199) == 0) drain_requests();
            send_request(pick_guest(), pick_target(), 1'b0, '0, pick_gap(sender_calm));
         end
      end

      drain_requests();
      repeat (80) @(posedge clock);
      if (failures == 0 && pending_slot_words.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
